>>> hw/rtl/png_chunk_stream_validator_unit_defines.svh
// assertion macros for the png chunk stream validator checker
`ifndef PNG_CHUNK_STREAM_VALIDATOR_UNIT_DEFINES_SVH
`define PNG_CHUNK_STREAM_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define PCSV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define PCSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define PCSV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pcsv_pkg.sv
// shared types, constants, signature byte and crc functions for the png chunk stream validator
package pcsv_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BAD_SIG  = 3'd1;
    localparam t_status ST_TRUNC    = 3'd2;
    localparam t_status ST_CRC_ERR  = 3'd3;
    localparam t_status ST_MISSING  = 3'd4;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    // an unfinished chunk with fewer than four data and crc bytes counts as trailing junk
    localparam logic [33:0] MIN_PART  = 34'd4;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // reflected crc-32, one byte, eight bit steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/png_chunk_stream_validator_unit.sv
// png chunk stream validator: signature, chunk walk, crc-32 check and verdict
// datapath: a byte taken into the input register updates the parser state and, if it is
//   the last byte, loads the verdict into the result register that drives o_out_valid
// throughput: one byte per cycle while no last byte waits on a stalled result register,
//   set by the byte-wide crc-32 update and the 32-bit length counter in the single processing stage
// reset: synchronous, active low; clears the parser state and both valid flags
module png_chunk_stream_validator_unit
    import pcsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic       o_is_png,
    output logic [2:0] o_status,
    input  logic       i_out_stall
);

    // parser phases
    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    // parser state
    logic [2:0]  r_phase,   n_phase;
    logic [2:0]  r_sig_idx, n_sig_idx;
    logic [1:0]  r_fbi,     n_fbi;
    logic [31:0] r_len,     n_len;
    logic [31:0] r_rem,     n_rem;
    logic [31:0] r_type,    n_type;
    logic [31:0] r_crc,     n_crc;
    logic [31:0] r_stored,  n_stored;
    logic        r_seen_hdr, n_seen_hdr;
    logic        r_seen_end, n_seen_end;
    t_status     r_err,     n_err;

    // result register
    logic        r_out_valid;
    logic        r_is_png;
    t_status     r_status;

    logic        advance;
    logic        partial;
    t_status     verdict;
    logic [31:0] crc_next;

    // a plain byte always moves on; a last byte needs room in the result register
    assign advance    = r_in_valid && (!r_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    assign crc_next = crc_byte(r_crc, r_byte);

    always_comb begin
        n_phase    = r_phase;
        n_sig_idx  = r_sig_idx;
        n_fbi      = r_fbi;
        n_len      = r_len;
        n_rem      = r_rem;
        n_type     = r_type;
        n_crc      = r_crc;
        n_stored   = r_stored;
        n_seen_hdr = r_seen_hdr;
        n_seen_end = r_seen_end;
        n_err      = r_err;

        // consume one byte unless a failure is already latched
        if (r_err == ST_OK) begin
            case (r_phase)
                PH_SIG: begin
                    if (r_byte != sig_byte(r_sig_idx)) begin
                        n_err = ST_BAD_SIG;
                    end else if (r_sig_idx == 3'd7) begin
                        n_phase = PH_LEN;
                        n_fbi   = 2'd0;
                        n_len   = 32'd0;
                    end else begin
                        n_sig_idx = r_sig_idx + 3'd1;
                    end
                end
                PH_LEN: begin
                    n_len = {r_len[23:0], r_byte};
                    if (r_fbi == 2'd3) begin
                        n_phase = PH_TYPE;
                        n_fbi   = 2'd0;
                        n_type  = 32'd0;
                        n_crc   = CRC_INIT;
                    end else begin
                        n_fbi = r_fbi + 2'd1;
                    end
                end
                PH_TYPE: begin
                    n_type = {r_type[23:0], r_byte};
                    n_crc  = crc_next;
                    if (r_fbi == 2'd3) begin
                        n_fbi    = 2'd0;
                        n_rem    = r_len;
                        n_stored = 32'd0;
                        n_phase  = (r_len == 32'd0) ? PH_CRC : PH_DATA;
                    end else begin
                        n_fbi = r_fbi + 2'd1;
                    end
                end
                PH_DATA: begin
                    n_crc = crc_next;
                    n_rem = r_rem - 32'd1;
                    if (n_rem == 32'd0) begin
                        n_phase = PH_CRC;
                        n_fbi   = 2'd0;
                    end
                end
                PH_CRC: begin
                    n_stored = {r_stored[23:0], r_byte};
                    if (r_fbi == 2'd3) begin
                        // end of chunk: check crc, then note ihdr / iend
                        if (~r_crc != n_stored) begin
                            n_err = ST_CRC_ERR;
                        end else begin
                            if (r_type == TYPE_IHDR) begin
                                n_seen_hdr = 1'b1;
                            end
                            if (r_type == TYPE_IEND) begin
                                n_seen_end = 1'b1;
                                n_phase    = PH_DONE;
                            end else begin
                                n_phase = PH_LEN;
                                n_fbi   = 2'd0;
                                n_len   = 32'd0;
                            end
                        end
                    end else begin
                        n_fbi = r_fbi + 2'd1;
                    end
                end
                default: begin
                    // after iend: bytes are ignored
                end
            endcase
        end

        // four or more data and crc bytes of an unfinished chunk make a truncated file
        case (n_phase)
            PH_DATA: partial = (n_len - n_rem) >= MIN_PART[31:0];
            PH_CRC:  partial = ({2'd0, n_len} + {32'd0, n_fbi}) >= MIN_PART;
            default: partial = 1'b0;
        endcase

        if (n_err != ST_OK) begin
            verdict = n_err;
        end else if (n_phase == PH_SIG) begin
            verdict = ST_BAD_SIG;
        end else if (partial) begin
            verdict = ST_TRUNC;
        end else if (!n_seen_hdr || !n_seen_end) begin
            verdict = ST_MISSING;
        end else begin
            verdict = ST_OK;
        end

        // the last byte of a file sends the parser back to its reset state
        if (r_last) begin
            n_phase    = PH_SIG;
            n_sig_idx  = 3'd0;
            n_fbi      = 2'd0;
            n_len      = 32'd0;
            n_rem      = 32'd0;
            n_type     = 32'd0;
            n_crc      = CRC_INIT;
            n_stored   = 32'd0;
            n_seen_hdr = 1'b0;
            n_seen_end = 1'b0;
            n_err      = ST_OK;
        end
    end

    // input register: loads whenever the held request moves on or is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIG;
            r_sig_idx  <= 3'd0;
            r_fbi      <= 2'd0;
            r_len      <= 32'd0;
            r_rem      <= 32'd0;
            r_type     <= 32'd0;
            r_crc      <= CRC_INIT;
            r_stored   <= 32'd0;
            r_seen_hdr <= 1'b0;
            r_seen_end <= 1'b0;
            r_err      <= ST_OK;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_sig_idx  <= n_sig_idx;
            r_fbi      <= n_fbi;
            r_len      <= n_len;
            r_rem      <= n_rem;
            r_type     <= n_type;
            r_crc      <= n_crc;
            r_stored   <= n_stored;
            r_seen_hdr <= n_seen_hdr;
            r_seen_end <= n_seen_end;
            r_err      <= n_err;
        end
    end

    // result register: holds the verdict until the far side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_status <= verdict;
            r_is_png <= (verdict == ST_OK);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_png    = r_is_png;
    assign o_status    = r_status;

endmodule

>>> hw/rtl/pcsv_checker.sv
// port-level checker for the png chunk stream validator, bound to the validator unit
`include "png_chunk_stream_validator_unit_defines.svh"

module pcsv_checker
    import pcsv_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_last_byte,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       o_is_png,
    input logic [2:0] o_status,
    input logic       i_out_stall
);

    `PCSV_ASSERT_NOW(a_png_matches_ok, i_clk, i_rst_n, o_out_valid, (o_is_png == (o_status == ST_OK)), "is_png disagrees with status")
    `PCSV_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_out_valid, (o_status <= ST_MISSING), "status code out of range")
    `PCSV_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, (o_out_valid && i_out_stall), (o_out_valid && $stable(o_status) && $stable(o_is_png)), "stalled verdict changed")
    `PCSV_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, (!i_rst_n), (!o_out_valid && !o_in_stall), "valid or stall left after reset")
    `PCSV_ASSERT_NEXT(a_result_needs_last, i_clk, i_rst_n, ((!o_in_stall && !(i_in_valid && i_last_byte)) ##1 !o_out_valid), (!o_out_valid), "verdict without a last byte")

endmodule

bind png_chunk_stream_validator_unit pcsv_checker u_pcsv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_last_byte (i_last_byte),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_is_png    (o_is_png),
    .o_status    (o_status),
    .i_out_stall (i_out_stall)
);
